### src/lcp_pkg.sv
package lcp_pkg;

	localparam int CAP     = 16;
	localparam int IDX_W   = $clog2(CAP);
	localparam int CNT_W   = $clog2(CAP + 1);
	localparam int Q_DEPTH = 2;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic              action;
		logic signed [31:0] key;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic signed [31:0] data_out;
		logic              evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	// Handshake between the request queue and the back end.
	typedef struct packed {
		logic avail;
		req_t head;
	} q_head_t;

endpackage

### src/lcp_front.sv
module lcp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lcp_pkg::req_t in_data,
	input  logic          pop,
	output lcp_pkg::q_head_t q_head
);
	import lcp_pkg::*;

	req_t         mem_q [Q_DEPTH];
	logic [0:0]   wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push, do_pop;

	assign in_stall    = (count_q == 2'(Q_DEPTH));
	assign push        = in_valid && !in_stall;
	assign do_pop      = pop && (count_q != 2'd0);
	assign q_head.avail = (count_q != 2'd0);
	assign q_head.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(Q_DEPTH)) else $error("request queue overfilled");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers disagree");
	a_full_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(Q_DEPTH)) |-> (wr_ptr_q == rd_ptr_q)) else $error("queue full mismatch");

endmodule

### src/lcp_back.sv
module lcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lcp_pkg::q_head_t q_head,
	output logic             pop,
	input  logic [4:0]       capacity,
	output logic             out_valid,
	input  logic             out_stall,
	output lcp_pkg::rsp_t    out_data
);
	import lcp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [IDX_W-1:0]   idx_q;

	logic               valid_q [CAP];
	logic [IDX_W-1:0]   rank_q  [CAP];
	logic [31:0]        key_q   [CAP];
	logic [31:0]        val_q   [CAP];
	logic [31:0]        cnt_q   [CAP];

	logic               m_found_q, free_found_q, v_found_q;
	logic [IDX_W-1:0]   m_idx_q, free_idx_q, v_idx_q;
	logic [IDX_W-1:0]   m_rank_q, v_rank_q;
	logic [31:0]        m_val_q, v_cnt_q, v_key_q;
	logic [CNT_W-1:0]   used_q;

	logic               out_valid_q;
	rsp_t               out_q;

	logic [CNT_W-1:0]   eff;
	logic               can_fire, fire, is_put, do_touch, do_ins, need_ev, ev, do_wr;
	logic [IDX_W-1:0]   slot;
	logic               better;
	rsp_t               rsp;

	assign eff      = (capacity > 5'(CAP)) ? CNT_W'(CAP) : CNT_W'(capacity);
	assign can_fire = !out_valid_q || !out_stall;
	assign fire     = (state_q == S_APPLY) && can_fire;
	assign is_put   = (req_q.action == ACT_PUT);
	assign do_touch = m_found_q && (!is_put || eff != '0);
	assign do_ins   = is_put && (eff != '0) && !m_found_q;
	assign need_ev  = (used_q >= eff) || !free_found_q;
	assign ev       = do_ins && need_ev && v_found_q;
	assign do_wr    = do_ins && (!need_ev || v_found_q);
	assign slot     = need_ev ? v_idx_q : free_idx_q;
	assign pop      = (state_q == S_IDLE) && q_head.avail;

	assign better = !v_found_q || (cnt_q[idx_q] < v_cnt_q) ||
	                ((cnt_q[idx_q] == v_cnt_q) && (rank_q[idx_q] > v_rank_q));

	always_comb begin
		rsp.hit         = m_found_q;
		rsp.data_out    = is_put ? 32'sd0 : (m_found_q ? $signed(m_val_q) : -32'sd1);
		rsp.evicted     = ev;
		rsp.evicted_key = ev ? $signed(v_key_q) : 32'sd0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sequencer: one entry examined per cycle, then an update step that waits until the output register frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_head.avail) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(CAP - 1)) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (can_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q        <= q_head.head;
			m_found_q    <= 1'b0;
			free_found_q <= 1'b0;
			v_found_q    <= 1'b0;
			used_q       <= '0;
		end
		if (state_q == S_SCAN) begin
			if (valid_q[idx_q]) begin
				used_q <= used_q + 1'b1;
				if (!m_found_q && key_q[idx_q] == req_q.key) begin
					m_found_q <= 1'b1;
					m_idx_q   <= idx_q;
					m_val_q   <= val_q[idx_q];
					m_rank_q  <= rank_q[idx_q];
				end
				if (better) begin
					v_found_q <= 1'b1;
					v_idx_q   <= idx_q;
					v_cnt_q   <= cnt_q[idx_q];
					v_rank_q  <= rank_q[idx_q];
					v_key_q   <= key_q[idx_q];
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
		end
		if (fire) out_q <= rsp;
		if (fire && do_touch) begin
			if (is_put) val_q[m_idx_q] <= req_q.data_in;
			if (cnt_q[m_idx_q] != 32'hFFFF_FFFF) cnt_q[m_idx_q] <= cnt_q[m_idx_q] + 32'd1;
		end
		if (fire && do_wr) begin
			key_q[slot] <= req_q.key;
			val_q[slot] <= req_q.data_in;
			cnt_q[slot] <= 32'd1;
		end
	end

	// Recency lanes: every entry updates its own rank in parallel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (fire) begin
			for (int i = 0; i < CAP; i++) begin
				if (do_touch) begin
					if (IDX_W'(i) == m_idx_q) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < m_rank_q) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (do_wr) begin
					if (IDX_W'(i) == slot) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i] && !(ev && rank_q[i] > v_rank_q)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.evicted) |-> !out_q.hit) else $error("eviction on a hit");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SCAN) |-> (idx_q == '0)) else $error("scan began mid-table");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q) else $error("result dropped under stall");

endmodule

### src/lfu_cache_policy.sv
// LFU cache policy table with least-recently-touched tie-break.
// Requests arrive on in_valid/in_stall carrying in_data (action, key,
// data_in); a request is taken on a clock edge with in_valid high and
// in_stall low. Each request yields exactly one response on
// out_valid/out_stall carrying out_data (hit, data_out, evicted,
// evicted_key), in request order.
// The capacity register is written on cfg_valid and cfg_ready; cfg_ready is
// always high, and the register should be written only while the block is idle.
// A two-entry request queue sits in front of the table sequencer, so requests
// are taken while the sequencer works on an earlier one.
// Each request is taken from the queue, then each of the 16 table entries is
// examined in turn for the match and victim scan, and an update step applies it.
// If the receiver stalls, the response is held in the output register; the
// next request still scans, but waits in its update cycle until the
// output register frees.
// Reset (arst_n low) empties the table and the queue and sets capacity to 16.
module lfu_cache_policy (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lcp_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output lcp_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data
);
	import lcp_pkg::*;

	q_head_t    q_head;
	logic       pop;
	logic [4:0] capacity_q;

	assign cfg_ready = 1'b1;

	// The capacity register; values above the table size are clipped in the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 5'(CAP);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.pop      (pop),
		.q_head   (q_head)
	);

	lcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.pop       (pop),
		.capacity  (capacity_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
